@@ design/hpc_pkg.sv @@
package hpc_pkg;

    localparam logic [3:0] PREFIX_BYTES = 4'd10;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] ETH_HEADER = 8'd14;

    localparam logic [63:0] PATTERN_HEAD_RESET = 64'h4745_5420_2F62_6C6F;
    localparam logic [15:0] PATTERN_TAIL_RESET = 16'h636B;
    localparam logic [3:0] PATTERN_LENGTH_RESET = 4'd10;
    localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd7;

    typedef enum logic [1:0] {
        CFG_PATTERN_HEAD,
        CFG_PATTERN_TAIL,
        CFG_PATTERN_LENGTH,
        CFG_MIN_PAYLOAD
    } cfg_index_t;

    typedef enum logic [2:0] {
        R_MATCH,
        R_NOT_IPV4,
        R_NOT_TCP,
        R_BAD_IHL,
        R_SHORT_PAYLOAD,
        R_MISMATCH,
        R_TRUNCATED
    } reason_t;

    typedef struct packed {
        logic [63:0] pattern_head;
        logic [15:0] pattern_tail;
        logic [3:0]  pattern_length;
        logic [15:0] min_payload;
    } cfg_t;

    typedef struct packed {
        logic        keep;
        reason_t     reason;
        logic [7:0]  payload_start;
    } result_t;

    function automatic logic [3:0] prefix_len(input logic [3:0] len);
        return (len > PREFIX_BYTES) ? PREFIX_BYTES : len;
    endfunction

    function automatic logic [7:0] pattern_byte(input logic [63:0] head,
                                                input logic [15:0] tail,
                                                input logic [3:0] k);
        logic [63:0] shifted;
        shifted = head << {k[2:0], 3'b000};
        if (k < 4'd8) begin
            return shifted[63:56];
        end else if (k == 4'd8) begin
            return tail[15:8];
        end else begin
            return tail[7:0];
        end
    endfunction

endpackage

@@ design/http_prefix_packet_classifier.sv @@
// Classifies Ethernet frames carrying IPv4/TCP by the first bytes of the TCP payload.
// Input channel (s_): one frame byte per transfer, starting at the destination MAC
// address, with s_last_byte marking the final byte of the frame.
// Result channel (m_): one transfer per frame, issued for its last byte, giving keep,
// a reason code and the byte offset of the TCP payload.
// Configuration channel (cfg_): writes the prefix, its length and the minimum payload
// length by register index; it is always ready and should be used between frames.
// A last byte passes the input register and then the result register, which drives
// m_valid. Every byte is registered at the input, and the header capture, prefix compare
// and decision are made from the input register straight into the result register.
// Throughput is one byte per cycle, set by the single registered parsing pass, but
// when the receiver stalls with a result pending, non-last bytes keep flowing; the
// next last byte waits in the input register until the pending result is transferred.
// A synchronous reset restores the default prefix and limits, empties both registers
// and clears the per-frame state, so the next byte is taken as the start of a frame.
module http_prefix_packet_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_keep,
    output logic [2:0]  m_reason,
    output logic [7:0]  m_payload_start,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    hpc_pkg::cfg_t    cfg;
    hpc_pkg::result_t res;
    logic             in_valid;
    logic [7:0]       in_byte;
    logic             in_last;
    logic             out_free;
    logic             take;

    assign take = in_valid && (!in_last || out_free);

    hpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hpc_in_reg u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packet_byte (s_packet_byte),
        .s_last_byte   (s_last_byte),
        .take          (take),
        .in_valid      (in_valid),
        .in_byte       (in_byte),
        .in_last       (in_last)
    );

    hpc_frame_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .byte_in (in_byte),
        .last_in (in_last),
        .cfg     (cfg),
        .res     (res)
    );

    hpc_result_reg u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (take && in_last),
        .res             (res),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_keep          (m_keep),
        .m_reason        (m_reason),
        .m_payload_start (m_payload_start)
    );

endmodule

@@ design/hpc_cfg_regs.sv @@
module hpc_cfg_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    output hpc_pkg::cfg_t          cfg
);

    hpc_pkg::cfg_t cfg_reg;
    hpc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (hpc_pkg::cfg_index_t'(cfg_index))
                hpc_pkg::CFG_PATTERN_HEAD:   cfg_next.pattern_head = cfg_data;
                hpc_pkg::CFG_PATTERN_TAIL:   cfg_next.pattern_tail = cfg_data[15:0];
                hpc_pkg::CFG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[3:0];
                hpc_pkg::CFG_MIN_PAYLOAD:    cfg_next.min_payload = cfg_data[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_head <= hpc_pkg::PATTERN_HEAD_RESET;
            cfg_reg.pattern_tail <= hpc_pkg::PATTERN_TAIL_RESET;
            cfg_reg.pattern_length <= hpc_pkg::PATTERN_LENGTH_RESET;
            cfg_reg.min_payload <= hpc_pkg::MIN_PAYLOAD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/hpc_in_reg.sv @@
module hpc_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_packet_byte,
    input  logic       s_last_byte,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_ready = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_byte = byte_reg;
    assign in_last = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_packet_byte;
            last_reg <= s_last_byte;
        end
    end

endmodule

@@ design/hpc_frame_parser.sv @@
module hpc_frame_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       byte_in,
    input  logic             last_in,
    input  hpc_pkg::cfg_t    cfg,
    output hpc_pkg::result_t res
);

    logic [15:0]      pos_reg, pos_next;
    logic [15:0]      ether_reg, ether_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [15:0]      total_reg, total_next;
    logic [3:0]       thw_reg, thw_next;
    logic             tcp_seen_reg, tcp_seen_next;
    logic             prefix_ok_reg, prefix_ok_next;
    hpc_pkg::reason_t fail_reg, fail_next;
    logic [7:0]       start_reg, start_next;

    logic [3:0]       plen;
    logic [7:0]       offpos;
    logic             capture;
    logic [7:0]       start_new;
    logic [16:0]      diff;
    logic             in_window;
    logic [3:0]       k;
    logic             cmp_en;
    logic             mismatch;
    logic [16:0]      n;
    logic [17:0]      plength;
    logic [16:0]      need;
    hpc_pkg::reason_t reason;

    always_comb begin
        plen = hpc_pkg::prefix_len(cfg.pattern_length);

        ether_next = ether_reg;
        ihl_next = ihl_reg;
        total_next = total_reg;
        fail_next = fail_reg;
        if (pos_reg == 16'd12) begin
            ether_next = {byte_in, ether_reg[7:0]};
        end else if (pos_reg == 16'd13) begin
            ether_next = {ether_reg[15:8], byte_in};
        end else if (pos_reg == 16'd14) begin
            ihl_next = byte_in[3:0];
        end else if (pos_reg == 16'd16) begin
            total_next = {byte_in, total_reg[7:0]};
        end else if (pos_reg == 16'd17) begin
            total_next = {total_reg[15:8], byte_in};
        end else if (pos_reg == 16'd23) begin
            priority if (ether_reg != hpc_pkg::ETHERTYPE_IPV4) begin
                fail_next = hpc_pkg::R_NOT_IPV4;
            end else if (byte_in != hpc_pkg::PROTO_TCP) begin
                fail_next = hpc_pkg::R_NOT_TCP;
            end else if (ihl_reg < 4'd5) begin
                fail_next = hpc_pkg::R_BAD_IHL;
            end else begin
                fail_next = hpc_pkg::R_MATCH;
            end
        end

        offpos = 8'd26 + {2'b00, ihl_reg, 2'b00};
        capture = (pos_reg > 16'd14) && (ihl_reg >= 4'd5)
                  && (pos_reg == {8'd0, offpos}) && !tcp_seen_reg;
        start_new = hpc_pkg::ETH_HEADER + {2'b00, ihl_reg, 2'b00}
                    + {2'b00, byte_in[7:4], 2'b00};
        thw_next = capture ? byte_in[7:4] : thw_reg;
        start_next = capture ? start_new : start_reg;
        tcp_seen_next = tcp_seen_reg || capture;

        diff = {1'b0, pos_reg} - {9'd0, start_reg};
        in_window = tcp_seen_reg && !diff[16] && (diff[15:0] < {12'd0, plen});
        k = capture ? 4'd0 : diff[3:0];
        cmp_en = in_window || (capture && (byte_in[7:4] == 4'd3) && (plen != 4'd0));
        mismatch = cmp_en
                   && (byte_in != hpc_pkg::pattern_byte(cfg.pattern_head,
                                                        cfg.pattern_tail, k));
        prefix_ok_next = prefix_ok_reg && !mismatch
                         && !(capture && (byte_in[7:4] < 4'd3));

        pos_next = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;

        n = {1'b0, pos_reg} + 17'd1;
        plength = {2'b00, total_next} - {12'd0, ihl_next, 2'b00}
                  - {12'd0, thw_next, 2'b00};
        need = {9'd0, start_next} + {13'd0, plen};

        priority if (n < 17'd14) begin
            reason = hpc_pkg::R_TRUNCATED;
        end else if (ether_next != hpc_pkg::ETHERTYPE_IPV4) begin
            reason = hpc_pkg::R_NOT_IPV4;
        end else if (n < 17'd24) begin
            reason = hpc_pkg::R_TRUNCATED;
        end else if (fail_next != hpc_pkg::R_MATCH) begin
            reason = fail_next;
        end else if (!tcp_seen_next) begin
            reason = hpc_pkg::R_TRUNCATED;
        end else if ($signed(plength) < $signed({2'b00, cfg.min_payload})) begin
            reason = hpc_pkg::R_SHORT_PAYLOAD;
        end else if (n < need) begin
            reason = hpc_pkg::R_TRUNCATED;
        end else if (!prefix_ok_next) begin
            reason = hpc_pkg::R_MISMATCH;
        end else begin
            reason = hpc_pkg::R_MATCH;
        end

        res.keep = (reason == hpc_pkg::R_MATCH);
        res.reason = reason;
        res.payload_start = tcp_seen_next ? start_next : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_in)) begin
            pos_reg <= 16'd0;
            ether_reg <= 16'd0;
            ihl_reg <= 4'd0;
            total_reg <= 16'd0;
            thw_reg <= 4'd0;
            tcp_seen_reg <= 1'b0;
            prefix_ok_reg <= 1'b1;
            fail_reg <= hpc_pkg::R_MATCH;
            start_reg <= 8'd0;
        end else if (step) begin
            pos_reg <= pos_next;
            ether_reg <= ether_next;
            ihl_reg <= ihl_next;
            total_reg <= total_next;
            thw_reg <= thw_next;
            tcp_seen_reg <= tcp_seen_next;
            prefix_ok_reg <= prefix_ok_next;
            fail_reg <= fail_next;
            start_reg <= start_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && last_in |=> pos_reg == 16'd0 && tcp_seen_reg == 1'b0)
        else $error("Frame state not cleared after the last byte.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !prefix_ok_reg |-> tcp_seen_reg)
        else $error("Prefix failure recorded before the data offset was seen.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        tcp_seen_reg |-> start_reg >= 8'd34 && ihl_reg >= 4'd5)
        else $error("Payload start inconsistent with the captured header lengths.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && last_in && res.keep |-> tcp_seen_next && prefix_ok_next)
        else $error("Frame kept without a seen and matching payload prefix.");

endmodule

@@ design/hpc_result_reg.sv @@
module hpc_result_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  hpc_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_keep,
    output logic [2:0]       m_reason,
    output logic [7:0]       m_payload_start
);

    logic             valid_reg;
    hpc_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_keep = res_reg.keep;
    assign m_reason = res_reg.reason;
    assign m_payload_start = res_reg.payload_start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("Result loaded over one that has not been transferred.");

endmodule
